>>> rtl/timed_relay_service_sequencer_defines.svh
// assertion macros for the timed relay service sequencer
// no dependencies; included by the top level
`ifndef TIMED_RELAY_SERVICE_SEQUENCER_DEFINES_SVH
`define TIMED_RELAY_SERVICE_SEQUENCER_DEFINES_SVH

`ifndef SYNTH
`define TRSS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define TRSS_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define TRSS_ASSERT(lbl, prop, msg)
`define TRSS_ASSERT_RST(lbl, prop, msg)
`endif

`endif

>>> rtl/trss_pkg.sv
// types and constants of the timed relay service sequencer
// no dependencies; imported by every module of the block
package trss_pkg;

   localparam int COUNT_W    = 24;
   localparam int LEN_W      = 16;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   typedef enum logic [1:0] {
      MODE_READY   = 2'd0,
      MODE_PREPARE = 2'd1,
      MODE_WORK    = 2'd2,
      MODE_FINAL   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      REG_INDICATOR_LEN = 2'd0,
      REG_CONTROL_LEN   = 2'd1,
      REG_SERVICE_LIMIT = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic event_valid;
      logic flag_prepare;
      logic flag_enable_indicator;
      logic flag_enable_control;
      logic flag_disable;
      logic done_sensor;
   } req_type;

   typedef struct packed {
      logic       indicator_relay;
      logic       control_relay;
      logic       timeout_notice;
      logic       done_notice;
      logic       prompt_refresh;
      logic [1:0] machine_mode;
   } rsp_type;

   typedef struct packed {
      logic [COUNT_W-1:0] indicator_limit;
      logic [COUNT_W-1:0] control_limit;
      logic [COUNT_W-1:0] service_limit;
   } cfg_type;

endpackage

>>> rtl/trss_csr.sv
// apb-style configuration registers, pulse lengths scaled to ticks on write
// depends on trss_pkg
module trss_csr import trss_pkg::*; #(
   parameter int TICKS_PER_CENTISECOND = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   logic [LEN_W-1:0]   ind_len_ff, ind_len_in;
   logic [LEN_W-1:0]   ctl_len_ff, ctl_len_in;
   logic [LEN_W-1:0]   svc_len_ff, svc_len_in;
   cfg_type            cfg_ff, cfg_in;
   logic               wr_en;
   reg_index_type      idx;
   logic [COUNT_W-1:0] scaled;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;
   assign idx    = reg_index_type'(paddr[3:2]);
   assign scaled = COUNT_W'(pwdata[LEN_W-1:0]) * COUNT_W'(TICKS_PER_CENTISECOND);

   always_comb begin
      ind_len_in = ind_len_ff;
      ctl_len_in = ctl_len_ff;
      svc_len_in = svc_len_ff;
      cfg_in     = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_INDICATOR_LEN: begin
               ind_len_in             = pwdata[LEN_W-1:0];
               cfg_in.indicator_limit = scaled;
            end
            REG_CONTROL_LEN: begin
               ctl_len_in           = pwdata[LEN_W-1:0];
               cfg_in.control_limit = scaled;
            end
            REG_SERVICE_LIMIT: begin
               svc_len_in           = pwdata[LEN_W-1:0];
               cfg_in.service_limit = scaled;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_INDICATOR_LEN: prdata = CSR_DATA_W'(ind_len_ff);
         REG_CONTROL_LEN:   prdata = CSR_DATA_W'(ctl_len_ff);
         REG_SERVICE_LIMIT: prdata = CSR_DATA_W'(svc_len_ff);
         default:           prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ind_len_ff <= '0;
         ctl_len_ff <= '0;
         svc_len_ff <= '0;
         cfg_ff     <= '0;
      end else begin
         ind_len_ff <= ind_len_in;
         ctl_len_ff <= ctl_len_in;
         svc_len_ff <= svc_len_in;
         cfg_ff     <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> rtl/trss_core.sv
// sequencer state, relay flags and elapsed counters, one tick per accepted request
// depends on trss_pkg
module trss_core import trss_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    tick,
   input  req_type req,
   input  cfg_type cfg,
   output rsp_type rsp
);

   localparam logic [3:0] CODE_BOTH      = 4'b0110;
   localparam logic [3:0] CODE_CONTROL   = 4'b0100;
   localparam logic [3:0] CODE_INDICATOR = 4'b0010;
   localparam logic [3:0] CODE_DISABLE   = 4'b1000;

   mode_type           mode_ff, mode_in;
   logic               ind_on_ff, ind_on_in;
   logic               ctl_on_ff, ctl_on_in;
   logic [COUNT_W-1:0] ind_cnt_ff, ind_cnt_in;
   logic [COUNT_W-1:0] ctl_cnt_ff, ctl_cnt_in;
   logic [COUNT_W-1:0] svc_cnt_ff, svc_cnt_in;

   function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] c);
      return (c == COUNT_MAX) ? COUNT_MAX : c + COUNT_W'(1);
   endfunction

   always_comb begin
      logic [3:0] code;
      code       = {req.flag_disable, req.flag_enable_control,
                    req.flag_enable_indicator, req.flag_prepare};
      ind_cnt_in = bump(ind_cnt_ff);
      ctl_cnt_in = bump(ctl_cnt_ff);
      svc_cnt_in = bump(svc_cnt_ff);
      ind_on_in  = ind_on_ff && !(ind_cnt_in > cfg.indicator_limit);
      ctl_on_in  = ctl_on_ff && !(ctl_cnt_in > cfg.control_limit);
      mode_in    = mode_ff;
      rsp        = '0;
      unique case (mode_ff)
         MODE_READY: begin
            if (req.event_valid && req.flag_prepare) begin
               mode_in = MODE_PREPARE;
            end
         end
         MODE_PREPARE: begin
            if (req.event_valid) begin
               priority if (code == CODE_BOTH || code == CODE_CONTROL) begin
                  if (code == CODE_BOTH) begin
                     ind_on_in  = 1'b1;
                     ind_cnt_in = '0;
                  end
                  ctl_on_in  = 1'b1;
                  ctl_cnt_in = '0;
                  svc_cnt_in = '0;
                  mode_in    = MODE_WORK;
               end else if (code == CODE_INDICATOR) begin
                  ind_on_in  = 1'b1;
                  ind_cnt_in = '0;
                  mode_in    = MODE_READY;
               end else if (code == CODE_DISABLE) begin
                  ind_on_in = 1'b0;
                  mode_in   = MODE_READY;
               end else begin
               end
            end
         end
         MODE_WORK: begin
            priority if (svc_cnt_in > cfg.service_limit) begin
               rsp.timeout_notice = 1'b1;
               mode_in            = MODE_FINAL;
            end else if (req.done_sensor) begin
               ctl_on_in       = 1'b0;
               rsp.done_notice = 1'b1;
               mode_in         = MODE_FINAL;
            end else begin
            end
         end
         MODE_FINAL: begin
            mode_in = MODE_READY;
         end
         default: begin
            mode_in = MODE_READY;
         end
      endcase
      rsp.indicator_relay = ind_on_in;
      rsp.control_relay   = ctl_on_in;
      rsp.prompt_refresh  = rsp.timeout_notice || rsp.done_notice;
      rsp.machine_mode    = mode_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_READY;
         ind_on_ff  <= 1'b0;
         ctl_on_ff  <= 1'b0;
         ind_cnt_ff <= '0;
         ctl_cnt_ff <= '0;
         svc_cnt_ff <= '0;
      end else if (tick) begin
         mode_ff    <= mode_in;
         ind_on_ff  <= ind_on_in;
         ctl_on_ff  <= ctl_on_in;
         ind_cnt_ff <= ind_cnt_in;
         ctl_cnt_ff <= ctl_cnt_in;
         svc_cnt_ff <= svc_cnt_in;
      end
   end

endmodule

>>> rtl/trss_rsp_buf.sv
// two-entry result buffer: output register plus skid register
// depends on trss_pkg
module trss_rsp_buf import trss_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    full,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_data_ff, out_data_in;
   rsp_type skid_data_ff, skid_data_in;
   logic    pop;

   assign pop = out_valid_ff && !rsp_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || pop) begin
         out_valid_in = skid_valid_ff || push;
         out_data_in  = skid_valid_ff ? skid_data_ff : push_data;
         if (skid_valid_ff) begin
            skid_valid_in = push;
            skid_data_in  = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign full        = skid_valid_ff;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_data_ff;

endmodule

>>> rtl/timed_relay_service_sequencer.sv
// top level of the timed relay service sequencer
// depends on trss_pkg, trss_csr, trss_core, trss_rsp_buf and the defines header

// One request is one base tick. A request is taken in every cycle in which the
// two-entry result buffer has room, and its result is registered in the output
// register, or in the skid register behind an earlier result; the sustained
// rate is one tick per cycle while rsp_stall stays low. The sequencer update and
// the three counter compares sit between the state registers and the result
// register. Pulse lengths written through the apb port are scaled to ticks when
// written and read back as written. There is no clearing pass after reset.
`include "timed_relay_service_sequencer_defines.svh"
module timed_relay_service_sequencer import trss_pkg::*; #(
   parameter int TICKS_PER_CENTISECOND = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_payload,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type cfg;
   rsp_type core_rsp;
   logic    tick;
   logic    buf_full;

   assign req_stall = buf_full;
   assign tick      = req_valid && !req_stall;

   trss_csr #(
      .TICKS_PER_CENTISECOND(TICKS_PER_CENTISECOND)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   trss_core u_core (
      .clock (clock),
      .reset (reset),
      .tick  (tick),
      .req   (req_payload),
      .cfg   (cfg),
      .rsp   (core_rsp)
   );

   trss_rsp_buf u_rsp_buf (
      .clock       (clock),
      .reset       (reset),
      .push        (tick),
      .push_data   (core_rsp),
      .full        (buf_full),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   `TRSS_ASSERT(a_notice_excl, rsp_valid |-> !(rsp_payload.timeout_notice && rsp_payload.done_notice), "both notices set")
   `TRSS_ASSERT(a_notice_final, rsp_valid && rsp_payload.prompt_refresh |-> rsp_payload.machine_mode == MODE_FINAL, "notice outside final mode")
   `TRSS_ASSERT(a_stall_full, req_stall |-> rsp_valid, "stall with empty output register")
   `TRSS_ASSERT_RST(a_reset_empty, $past(reset) |-> !rsp_valid && !req_stall, "buffer not empty after reset")

endmodule
